// ----- rtl/pps_pkg.sv -----
// ============================================================================
// pps_pkg
// Shared types, codes and constants of the panel power sequencer.
// ============================================================================
`default_nettype none

package pps_pkg;

    // Width of the delay and power-cycle timers.
    localparam int TIMER_W = 16;
    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_W) - 33'd1;

    localparam int CFG_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int BRIGHT_W = 7;
    localparam int DUTY_W  = 16;

    localparam int FULL_DUTY = 65535;
    localparam int MAX_LEVEL = 100;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd80;

    // Input operation codes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_REQ   = 2'd1;
    localparam logic [1:0] OP_LEVEL = 2'd2;

    // Power states.
    localparam logic [1:0] PS_OFF   = 2'd0;
    localparam logic [1:0] PS_SLEEP = 2'd1;
    localparam logic [1:0] PS_DOZE  = 2'd2;
    localparam logic [1:0] PS_ON    = 2'd3;

    // Display modes.
    localparam logic [1:0] MODE_ON      = 2'd0;
    localparam logic [1:0] MODE_STANDBY = 2'd1;
    localparam logic [1:0] MODE_OFF     = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_POWER_UP_DELAY      = 3'd0;
    localparam logic [2:0] REG_POWER_DOWN_DELAY    = 3'd1;
    localparam logic [2:0] REG_BACKLIGHT_ON_DELAY  = 3'd2;
    localparam logic [2:0] REG_BACKLIGHT_OFF_DELAY = 3'd3;
    localparam logic [2:0] REG_POWER_CYCLE_DELAY   = 3'd4;
    localparam int         PADDR_W = 5;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_CYCLE = 6'b000010,
        PH_UP    = 6'b000100,
        PH_BLON  = 6'b001000,
        PH_BLOFF = 6'b010000,
        PH_DOWN  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         target_state;
        logic [LEVEL_W-1:0] level;
    } in_item_t;

    typedef struct packed {
        logic              panel_power;
        logic              backlight_on;
        logic [DUTY_W-1:0] pwm_duty;
        logic [1:0]        display_mode;
        logic [1:0]        power_state;
        logic              busy_res;
        logic              request_rejected;
    } out_item_t;

    typedef logic [DUTY_W-1:0] duty_lut_t [0:(1 << BRIGHT_W) - 1];

    // Duty for every brightness code, worked out at elaboration.
    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        for (int i = 0; i < (1 << BRIGHT_W); i++) begin
            lut[i] = DUTY_W'((i * FULL_DUTY) / MAX_LEVEL);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

    // A register value larger than the timer saturates at the timer maximum.
    function automatic logic [TIMER_W-1:0] clamp_timer(input logic [CFG_W-1:0] v);
        logic [32:0] wide;
        wide = 33'(v);
        if (wide > TIMER_MAX) begin
            return TIMER_W'(TIMER_MAX);
        end
        return TIMER_W'(wide);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/panel_power_sequencer.sv -----
// ============================================================================
// panel_power_sequencer
// Timed display-panel power and backlight sequencer.
// ============================================================================
// Items on the s_ channel are one-millisecond ticks, power-state requests
// (off, sleep, doze, on) and backlight level writes. Every accepted item
// produces exactly one status item on the m_ channel, showing the panel
// supply, backlight enable and duty, display mode, last accepted power state,
// whether a timed sequence runs, and whether this item was a rejected request.
// Delays are set through the APB port and count in ticks.
// The status of an item is in the output register in the cycle after it is
// accepted. Throughput is one item per cycle, set by the single state update
// between the sequencer and output registers, while the receiver keeps up.
// When the receiver stalls, the pending status holds and a new item is taken
// in the same cycle that the held one is taken; s_ready is low only while a
// status waits and m_ready is low.
// Reset returns the delays to their defaults, the sequencer to idle with the
// panel off, brightness 80 percent, and empties the output register.
// ============================================================================
`default_nettype none

module panel_power_sequencer import pps_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef struct packed {
        phase_t             phase;
        logic [TIMER_W-1:0] delay_count;
        logic [TIMER_W-1:0] since_switch;
        logic               ever_switched;
        logic               panel_ready;
        logic               backlight_enabled;
        logic               display_up;
        logic [1:0]         mode_now;
        logic [1:0]         state_now;
    } seq_state_t;

    localparam int SETTLE_STEPS = 3;

    logic [CFG_W-1:0] power_up_delay_reg;
    logic [CFG_W-1:0] power_down_delay_reg;
    logic [CFG_W-1:0] backlight_on_delay_reg;
    logic [CFG_W-1:0] backlight_off_delay_reg;
    logic [CFG_W-1:0] power_cycle_delay_reg;

    seq_state_t          seq_reg, seq_next;
    logic [BRIGHT_W-1:0] bright_reg, bright_next;
    logic                m_valid_reg;
    out_item_t           m_data_reg, m_data_next;
    logic                rejected;
    logic                s_fire;
    logic                cfg_write;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_up_delay_reg      <= 16'd200;
            power_down_delay_reg    <= 16'd500;
            backlight_on_delay_reg  <= 16'd100;
            backlight_off_delay_reg <= 16'd100;
            power_cycle_delay_reg   <= 16'd500;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                REG_POWER_UP_DELAY:      power_up_delay_reg      <= pwdata[CFG_W-1:0];
                REG_POWER_DOWN_DELAY:    power_down_delay_reg    <= pwdata[CFG_W-1:0];
                REG_BACKLIGHT_ON_DELAY:  backlight_on_delay_reg  <= pwdata[CFG_W-1:0];
                REG_BACKLIGHT_OFF_DELAY: backlight_off_delay_reg <= pwdata[CFG_W-1:0];
                REG_POWER_CYCLE_DELAY:   power_cycle_delay_reg   <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_POWER_UP_DELAY:      prdata = 32'(power_up_delay_reg);
            REG_POWER_DOWN_DELAY:    prdata = 32'(power_down_delay_reg);
            REG_BACKLIGHT_ON_DELAY:  prdata = 32'(backlight_on_delay_reg);
            REG_BACKLIGHT_OFF_DELAY: prdata = 32'(backlight_off_delay_reg);
            REG_POWER_CYCLE_DELAY:   prdata = 32'(power_cycle_delay_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer update
    // ------------------------------------------------------------------------
    function automatic seq_state_t enter_phase(input seq_state_t s, input phase_t ph,
                                               input logic [TIMER_W-1:0] d);
        seq_state_t r;
        r             = s;
        r.phase       = ph;
        r.delay_count = d;
        return r;
    endfunction

    // Closes a phase whose delay has run out and opens the next one.
    function automatic seq_state_t settle_step(input seq_state_t s);
        seq_state_t r;
        r = s;
        if (s.phase != PH_IDLE && s.delay_count == '0) begin
            unique case (s.phase)
                PH_CYCLE: begin
                    r = enter_phase(r, PH_UP, clamp_timer(power_up_delay_reg));
                end
                PH_UP: begin
                    r.panel_ready   = 1'b1;
                    r.since_switch  = '0;
                    r.ever_switched = 1'b1;
                    r = enter_phase(r, PH_BLON, clamp_timer(backlight_on_delay_reg));
                end
                PH_BLON: begin
                    r.backlight_enabled = 1'b1;
                    r.display_up        = 1'b1;
                    r.mode_now          = MODE_ON;
                    r = enter_phase(r, PH_IDLE, '0);
                end
                PH_BLOFF: begin
                    r = enter_phase(r, PH_DOWN, clamp_timer(power_down_delay_reg));
                end
                PH_DOWN: begin
                    r.panel_ready   = 1'b0;
                    r.since_switch  = '0;
                    r.ever_switched = 1'b1;
                    r.display_up    = 1'b0;
                    r.mode_now      = MODE_OFF;
                    r = enter_phase(r, PH_IDLE, '0);
                end
                default: begin
                    r = enter_phase(r, PH_IDLE, '0);
                end
            endcase
        end
        return r;
    endfunction

    function automatic seq_state_t start_request(input seq_state_t s, input logic [1:0] target);
        seq_state_t         r;
        logic [TIMER_W-1:0] cyc;
        logic [TIMER_W-1:0] wait_ticks;
        r          = s;
        cyc        = clamp_timer(power_cycle_delay_reg);
        wait_ticks = '0;
        r.state_now = target;
        unique case (target)
            PS_ON: begin
                if (!s.display_up) begin
                    // The power-cycle wait applies only once the panel has switched.
                    if (s.ever_switched && s.since_switch < cyc) begin
                        wait_ticks = cyc - s.since_switch;
                    end
                    r = enter_phase(r, PH_CYCLE, wait_ticks);
                end else if (!s.backlight_enabled) begin
                    r = enter_phase(r, PH_BLON, clamp_timer(backlight_on_delay_reg));
                end else begin
                    r.mode_now = MODE_ON;
                end
            end
            PS_DOZE: begin
                r.backlight_enabled = 1'b0;
                r.mode_now          = MODE_STANDBY;
            end
            default: begin
                r.backlight_enabled = 1'b0;
                if (s.display_up) begin
                    r = enter_phase(r, PH_BLOFF, clamp_timer(backlight_off_delay_reg));
                end else begin
                    r.mode_now = MODE_OFF;
                end
            end
        endcase
        return r;
    endfunction

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        seq_next    = seq_reg;
        bright_next = bright_reg;
        rejected    = 1'b0;
        unique case (s_data.op)
            OP_TICK: begin
                if (33'(seq_reg.since_switch) < TIMER_MAX) begin
                    seq_next.since_switch = seq_reg.since_switch + 1'b1;
                end
                if (seq_reg.phase != PH_IDLE && seq_reg.delay_count != '0) begin
                    seq_next.delay_count = seq_reg.delay_count - 1'b1;
                end
            end
            OP_REQ: begin
                if (seq_reg.phase != PH_IDLE) begin
                    rejected = 1'b1;
                end else begin
                    seq_next = start_request(seq_reg, s_data.target_state);
                end
            end
            OP_LEVEL: begin
                if (s_data.level > LEVEL_W'(MAX_LEVEL)) begin
                    bright_next = BRIGHT_W'(MAX_LEVEL);
                end else begin
                    bright_next = s_data.level[BRIGHT_W-1:0];
                end
            end
            default: begin
            end
        endcase
        // Steps whose delay is zero complete within the same item.
        for (int k = 0; k < SETTLE_STEPS; k++) begin
            seq_next = settle_step(seq_next);
        end

        m_data_next.panel_power      = (seq_next.phase == PH_UP) ||
                                       (seq_next.panel_ready && seq_next.phase != PH_DOWN);
        m_data_next.backlight_on     = seq_next.backlight_enabled;
        m_data_next.pwm_duty         = seq_next.backlight_enabled ? DUTY_LUT[bright_next] : '0;
        m_data_next.display_mode     = seq_next.mode_now;
        m_data_next.power_state      = seq_next.state_now;
        m_data_next.busy_res         = seq_next.phase != PH_IDLE;
        m_data_next.request_rejected = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg.phase             <= PH_IDLE;
            seq_reg.delay_count       <= '0;
            seq_reg.since_switch      <= '0;
            seq_reg.ever_switched     <= 1'b0;
            seq_reg.panel_ready       <= 1'b0;
            seq_reg.backlight_enabled <= 1'b0;
            seq_reg.display_up        <= 1'b0;
            seq_reg.mode_now          <= MODE_OFF;
            seq_reg.state_now         <= PS_OFF;
            bright_reg                <= BRIGHT_RESET;
            m_valid_reg               <= 1'b0;
        end else begin
            if (s_fire) begin
                seq_reg    <= seq_next;
                bright_reg <= bright_next;
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_reject_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.op == OP_REQ && seq_reg.phase != PH_IDLE
        |=> m_data.request_rejected && m_data.busy_res
            && m_data.power_state == $past(seq_reg.state_now))
        else $error("rejected request changed the power state");

    a_backlight_needs_supply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.backlight_on |-> m_data.panel_power)
        else $error("backlight enabled without panel supply");

    a_dark_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.backlight_on |-> m_data.pwm_duty == '0)
        else $error("nonzero duty while the backlight is off");

endmodule

`default_nettype wire

// ----- bench/tb_panel_power_sequencer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_panel_power_sequencer
// Self-checking bench for the panel power sequencer.
// ============================================================================
// A short table of directed items runs first, with the status typed in where
// it is obvious. Random phases follow, each under a new set of delays written
// and read back over APB. Most random items form complete power sequences
// (a request, then ticks until the sequence ends), mixed with level writes,
// refused requests and unused opcodes. One phase writes the largest delays
// and sends only items that need no timed step. A predictor in the bench
// tracks the sequencer and works out the status of every item, and a monitor
// checks the status items against it in order. Both channels idle at random.
// ============================================================================

module tb_panel_power_sequencer;
    import pps_pkg::*;

    localparam logic [1:0]         OP_UNUSED        = 2'd3;
    localparam logic [TIMER_W-1:0] SWITCH_TIMER_MAX = '1;
    localparam out_item_t          NO_STATUS        = '0;

    typedef struct {
        in_item_t  item;
        bit        has_typed;
        out_item_t typed_status;
    } step_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Predictor state.
    phase_t              seq_phase;
    logic [TIMER_W-1:0]  seq_left;
    logic [TIMER_W-1:0]  ticks_since_switch;
    bit                  ever_switched;
    bit                  panel_ready;
    bit                  bl_lit;
    bit                  display_up;
    logic [BRIGHT_W-1:0] brightness;
    logic [1:0]          mode_now;
    logic [1:0]          state_now;
    logic [CFG_W-1:0]    delay_reg [0:4];

    out_item_t           expected_status [$];
    int                  mismatch_count = 0;
    bit                  quiet = 1'b0;

    panel_power_sequencer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void reset_model();
        delay_reg[REG_POWER_UP_DELAY]      = 16'd200;
        delay_reg[REG_POWER_DOWN_DELAY]    = 16'd500;
        delay_reg[REG_BACKLIGHT_ON_DELAY]  = 16'd100;
        delay_reg[REG_BACKLIGHT_OFF_DELAY] = 16'd100;
        delay_reg[REG_POWER_CYCLE_DELAY]   = 16'd500;
        seq_phase          = PH_IDLE;
        seq_left           = '0;
        ticks_since_switch = '0;
        ever_switched      = 1'b0;
        panel_ready        = 1'b0;
        bl_lit             = 1'b0;
        display_up         = 1'b0;
        brightness         = BRIGHT_RESET;
        mode_now           = MODE_OFF;
        state_now          = PS_OFF;
    endfunction

    // The timer is as wide as the registers, so a delay never saturates.
    function automatic void enter_step(phase_t ph, logic [TIMER_W-1:0] ticks);
        seq_phase = ph;
        seq_left  = ticks;
    endfunction

    function automatic void end_step();
        case (seq_phase)
            PH_CYCLE: enter_step(PH_UP, delay_reg[REG_POWER_UP_DELAY]);
            PH_UP: begin
                panel_ready        = 1'b1;
                ticks_since_switch = '0;
                ever_switched      = 1'b1;
                enter_step(PH_BLON, delay_reg[REG_BACKLIGHT_ON_DELAY]);
            end
            PH_BLON: begin
                bl_lit     = 1'b1;
                display_up = 1'b1;
                mode_now   = MODE_ON;
                enter_step(PH_IDLE, '0);
            end
            PH_BLOFF: enter_step(PH_DOWN, delay_reg[REG_POWER_DOWN_DELAY]);
            PH_DOWN: begin
                panel_ready        = 1'b0;
                ticks_since_switch = '0;
                ever_switched      = 1'b1;
                display_up         = 1'b0;
                mode_now           = MODE_OFF;
                enter_step(PH_IDLE, '0);
            end
            default: enter_step(PH_IDLE, '0);
        endcase
    endfunction

    // Steps with a zero delay all complete within the same item.
    function automatic void settle_steps();
        for (int n = 0; n < 8 && seq_phase != PH_IDLE && seq_left == 0; n++) begin
            end_step();
        end
    endfunction

    function automatic void take_request(logic [1:0] tgt);
        logic [TIMER_W-1:0] wait_ticks;
        state_now = tgt;
        if (tgt == PS_ON) begin
            if (!display_up) begin
                wait_ticks = '0;
                if (ever_switched && ticks_since_switch < delay_reg[REG_POWER_CYCLE_DELAY]) begin
                    wait_ticks = delay_reg[REG_POWER_CYCLE_DELAY] - ticks_since_switch;
                end
                enter_step(PH_CYCLE, wait_ticks);
            end else if (!bl_lit) begin
                enter_step(PH_BLON, delay_reg[REG_BACKLIGHT_ON_DELAY]);
            end else begin
                mode_now = MODE_ON;
            end
        end else if (tgt == PS_DOZE) begin
            bl_lit   = 1'b0;
            mode_now = MODE_STANDBY;
        end else begin
            bl_lit = 1'b0;
            if (display_up) begin
                enter_step(PH_BLOFF, delay_reg[REG_BACKLIGHT_OFF_DELAY]);
            end else begin
                mode_now = MODE_OFF;
            end
        end
        settle_steps();
    endfunction

    function automatic out_item_t predict_status(in_item_t it);
        out_item_t st;
        bit        refused;
        refused = 1'b0;
        case (it.op)
            OP_TICK: begin
                if (ticks_since_switch != SWITCH_TIMER_MAX) begin
                    ticks_since_switch++;
                end
                if (seq_phase != PH_IDLE) begin
                    if (seq_left != 0) begin
                        seq_left--;
                    end
                    settle_steps();
                end
            end
            OP_REQ: begin
                if (seq_phase != PH_IDLE) begin
                    refused = 1'b1;
                end else begin
                    take_request(it.target_state);
                end
            end
            OP_LEVEL: begin
                brightness = (it.level > MAX_LEVEL) ? BRIGHT_W'(MAX_LEVEL)
                                                    : it.level[BRIGHT_W-1:0];
            end
            default: ;
        endcase
        st.panel_power      = (seq_phase == PH_UP) || (panel_ready && seq_phase != PH_DOWN);
        st.backlight_on     = bl_lit;
        st.pwm_duty         = bl_lit ? DUTY_W'((int'(brightness) * FULL_DUTY) / MAX_LEVEL)
                                     : '0;
        st.display_mode     = mode_now;
        st.power_state      = state_now;
        st.busy_res         = (seq_phase != PH_IDLE);
        st.request_rejected = refused;
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders; fields that an operation ignores carry random bits.
    // ------------------------------------------------------------------------
    function automatic in_item_t mk_tick();
        return '{OP_TICK, 2'($urandom()), 8'($urandom())};
    endfunction

    function automatic in_item_t mk_req(logic [1:0] tgt);
        return '{OP_REQ, tgt, 8'($urandom())};
    endfunction

    function automatic in_item_t mk_level(logic [LEVEL_W-1:0] lvl);
        return '{OP_LEVEL, 2'($urandom()), lvl};
    endfunction

    function automatic logic [CFG_W-1:0] rnd_delay(int hi);
        return CFG_W'($urandom_range(0, hi));
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input in_item_t it, input bit has_typed = 1'b0,
                             input out_item_t typed_status = '0);
        out_item_t predicted;
        int        gap;
        predicted = predict_status(it);
        expected_status.push_back(has_typed ? typed_status : predicted);
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
    endtask

    task automatic finish_sequence();
        while (seq_phase != PH_IDLE) send_item(mk_tick());
        wait_for_results();
    endtask

    task automatic apb_transfer(input bit wr, input logic [2:0] idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] rd;
        apb_transfer(1'b0, idx, 32'd0, rd);
        if (rd !== {16'd0, delay_reg[idx]}) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("register %0d readback: expected %h, actual %h",
                         idx, {16'd0, delay_reg[idx]}, rd);
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        logic [31:0] rd;
        apb_transfer(1'b1, idx, {16'd0, val}, rd);
        delay_reg[idx] = val;
        check_reg(idx);
    endtask

    // Registers change only with the sequencer idle and no status pending.
    task automatic configure(input logic [CFG_W-1:0] up, input logic [CFG_W-1:0] down,
                             input logic [CFG_W-1:0] bl_on, input logic [CFG_W-1:0] bl_off,
                             input logic [CFG_W-1:0] cycle);
        finish_sequence();
        write_reg(REG_POWER_UP_DELAY, up);
        write_reg(REG_POWER_DOWN_DELAY, down);
        write_reg(REG_BACKLIGHT_ON_DELAY, bl_on);
        write_reg(REG_BACKLIGHT_OFF_DELAY, bl_off);
        write_reg(REG_POWER_CYCLE_DELAY, cycle);
    endtask

    task automatic run_random(input int goal);
        int       done;
        int       pick;
        in_item_t it;
        done = 0;
        while (done < goal) begin
            pick = $urandom_range(0, 99);
            if (seq_phase == PH_IDLE) begin
                quiet = ($urandom_range(0, 5) == 0);
                if (pick < 45) begin
                    it = mk_req(PS_ON);
                end else if (pick < 63) begin
                    it = mk_req($urandom_range(0, 1) ? PS_SLEEP : PS_OFF);
                end else if (pick < 72) begin
                    it = mk_req(PS_DOZE);
                end else if (pick < 84) begin
                    it = mk_level($urandom_range(0, 1) ? 8'($urandom_range(0, 100))
                                                       : 8'($urandom()));
                end else if (pick < 95) begin
                    // Idle time lets the switch timer pass the power-cycle delay.
                    repeat ($urandom_range(1, 24)) begin
                        send_item(mk_tick());
                        done++;
                    end
                    continue;
                end else begin
                    it = in_item_t'(12'($urandom()));
                end
            end else begin
                if (pick < 78) begin
                    it = mk_tick();
                end else if (pick < 88) begin
                    it = mk_level(8'($urandom()));
                end else if (pick < 95) begin
                    it = mk_req(2'($urandom()));
                end else begin
                    it = in_item_t'(12'($urandom()));
                end
            end
            send_item(it);
            if (it.op != OP_UNUSED) begin
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : status_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("status item with none expected: %h", m_data);
                end
            end else begin
                want = expected_status.pop_front();
                if (m_data.panel_power !== want.panel_power ||
                    m_data.backlight_on !== want.backlight_on ||
                    m_data.pwm_duty !== want.pwm_duty ||
                    m_data.display_mode !== want.display_mode ||
                    m_data.power_state !== want.power_state ||
                    m_data.busy_res !== want.busy_res ||
                    m_data.request_rejected !== want.request_rejected) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("status mismatch: expected pwr=%0b bl=%0b duty=%0d mode=%0d",
                                 want.panel_power, want.backlight_on, want.pwm_duty,
                                 want.display_mode);
                        $display("  state=%0d busy=%0b rej=%0b; actual pwr=%0b bl=%0b duty=%0d",
                                 want.power_state, want.busy_res, want.request_rejected,
                                 m_data.panel_power, m_data.backlight_on, m_data.pwm_duty);
                        $display("  mode=%0d state=%0d busy=%0b rej=%0b",
                                 m_data.display_mode, m_data.power_state, m_data.busy_res,
                                 m_data.request_rejected);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        step_row_t rows [$];
        int        settle_wait;

        reset_model();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_reg(REG_POWER_UP_DELAY);
        check_reg(REG_POWER_DOWN_DELAY);
        check_reg(REG_BACKLIGHT_ON_DELAY);
        check_reg(REG_BACKLIGHT_OFF_DELAY);
        check_reg(REG_POWER_CYCLE_DELAY);

        configure(16'd1, 16'd0, 16'd0, 16'd1, 16'd3);

        // Directed walk: power-on without history, refused requests, level
        // clamping, doze, sleep, and a power-on that waits out the cycle time.
        rows.push_back('{mk_tick(), 1'b1,
                         '{1'b0, 1'b0, 16'd0, MODE_OFF, PS_OFF, 1'b0, 1'b0}});
        rows.push_back('{mk_level(8'd255), 1'b1,
                         '{1'b0, 1'b0, 16'd0, MODE_OFF, PS_OFF, 1'b0, 1'b0}});
        rows.push_back('{'{OP_UNUSED, PS_ON, 8'hff}, 1'b1,
                         '{1'b0, 1'b0, 16'd0, MODE_OFF, PS_OFF, 1'b0, 1'b0}});
        rows.push_back('{mk_req(PS_ON), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_OFF), 1'b1,
                         '{1'b1, 1'b0, 16'd0, MODE_OFF, PS_ON, 1'b1, 1'b1}});
        rows.push_back('{mk_tick(), 1'b1,
                         '{1'b1, 1'b1, 16'hffff, MODE_ON, PS_ON, 1'b0, 1'b0}});
        rows.push_back('{mk_level(8'd0), 1'b1,
                         '{1'b1, 1'b1, 16'd0, MODE_ON, PS_ON, 1'b0, 1'b0}});
        rows.push_back('{mk_level(8'd100), 1'b0, NO_STATUS});
        rows.push_back('{mk_level(8'd101), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_ON), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_DOZE), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_ON), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_SLEEP), 1'b0, NO_STATUS});
        rows.push_back('{mk_level(8'd50), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_ON), 1'b1,
                         '{1'b1, 1'b0, 16'd0, MODE_ON, PS_SLEEP, 1'b1, 1'b1}});
        rows.push_back('{mk_tick(), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_ON), 1'b0, NO_STATUS});
        rows.push_back('{mk_tick(), 1'b0, NO_STATUS});
        rows.push_back('{mk_tick(), 1'b0, NO_STATUS});
        rows.push_back('{mk_tick(), 1'b0, NO_STATUS});
        rows.push_back('{mk_tick(), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_OFF), 1'b0, NO_STATUS});
        rows.push_back('{mk_tick(), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_DOZE), 1'b0, NO_STATUS});
        rows.push_back('{mk_req(PS_OFF), 1'b0, NO_STATUS});
        foreach (rows[i]) begin
            send_item(rows[i].item, rows[i].has_typed, rows[i].typed_status);
        end
        wait_for_results();

        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(350);

        configure(rnd_delay(8), rnd_delay(8), rnd_delay(8), rnd_delay(8), rnd_delay(8));
        run_random(500);

        configure(rnd_delay(40), rnd_delay(40), rnd_delay(40), rnd_delay(40), rnd_delay(40));
        run_random(500);

        // Largest delays: only items that need no timed step are sent, so
        // the full-scale registers are read back without a long wait.
        configure(16'hffff, 16'd0, 16'd0, 16'd0, 16'hffff);
        quiet = 1'b1;
        if (display_up) begin
            send_item(mk_req(PS_OFF));
        end
        repeat (3) send_item(mk_tick());
        send_item(mk_level(8'd255));
        finish_sequence();
        quiet = 1'b0;
        write_reg(REG_POWER_DOWN_DELAY, 16'hffff);
        write_reg(REG_BACKLIGHT_ON_DELAY, 16'hffff);
        write_reg(REG_BACKLIGHT_OFF_DELAY, 16'hffff);
        send_item(mk_req(PS_DOZE));
        send_item(mk_level(8'd37));
        repeat (4) send_item(mk_tick());

        configure(rnd_delay(3), rnd_delay(3), rnd_delay(3), rnd_delay(3), rnd_delay(60));
        run_random(400);

        wait_for_results();
        settle_wait = 0;
        while (settle_wait < 20) begin
            @(posedge aclk);
            settle_wait++;
        end
        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
